// ===== src/xrg_pkg.sv =====
// Shared types and constants for the xoroshiro128++ generator.
package xrg_pkg;

    localparam logic [63:0] JUMP_POLY_LO  = 64'h2bd7a6a6e99c2ddc;
    localparam logic [63:0] JUMP_POLY_HI  = 64'h0992ccaf6a6fca05;
    localparam logic [63:0] LJUMP_POLY_LO = 64'h360fd5f2cf8d5d99;
    localparam logic [63:0] LJUMP_POLY_HI = 64'h9c6e6877736c46e3;

    typedef enum logic [2:0] {
        ACT_DRAW   = 3'd0,
        ACT_RANGED = 3'd1,
        ACT_JUMP   = 3'd2,
        ACT_LJUMP  = 3'd3,
        ACT_SEED   = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]         action;
        logic [63:0]        seed_value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_in_item;

    typedef struct packed {
        logic [63:0]        raw_value;
        logic signed [31:0] ranged_value;
    } t_out_item;

    // classified command passed from front to back
    typedef enum logic [2:0] {
        CMD_DRAW, CMD_RANGED, CMD_EQUAL, CMD_JUMP, CMD_LJUMP, CMD_SEED
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [63:0] seed_value;
        logic [31:0] low;
        logic [31:0] span;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_JUMP, ST_DIV, ST_OUT_WAIT
    } t_state;

endpackage

// ===== src/xrg_front.sv =====
// Front end: accept input transfers, classify them and queue commands.
module xrg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  xrg_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output xrg_pkg::t_cmd     o_cmd
);
    import xrg_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_keep, w_push, w_pop;

    always_comb begin
        w_cmd.seed_value = i_item.seed_value;
        w_cmd.low        = i_item.range_low;
        w_cmd.span       = i_item.range_high - i_item.range_low;
        w_keep           = 1'b1;
        w_cmd.kind       = CMD_DRAW;
        case (i_item.action)
            ACT_DRAW:   w_cmd.kind = CMD_DRAW;
            ACT_RANGED: w_cmd.kind = (w_cmd.span == 32'd0) ? CMD_EQUAL : CMD_RANGED;
            ACT_JUMP:   w_cmd.kind = CMD_JUMP;
            ACT_LJUMP:  w_cmd.kind = CMD_LJUMP;
            ACT_SEED:   w_cmd.kind = CMD_SEED;
            default:    w_keep = 1'b0;  // drop unused codes
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== src/xrg_back.sv =====
// Back end: generator state, jump sequencer, serial modulo and output register.
module xrg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  xrg_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output xrg_pkg::t_out_item o_item
);
    import xrg_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_a, r_b, r_acc_a, r_acc_b, r_pl, r_ph;
    logic [6:0]  r_step;
    logic [5:0]  r_bit;
    logic [31:0] r_rem, r_num, r_span, r_low;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out;
    logic [63:0] w_draw, w_na, w_nb, w_bx, w_poly;
    logic [32:0] w_trial;
    logic        w_take, w_space;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int k);
        return (v << k) | (v >> (64 - k));
    endfunction

    always_comb begin
        w_draw = rotl(r_a + r_b, 17) + r_a;
        w_bx   = r_b ^ r_a;
        w_na   = rotl(r_a, 49) ^ w_bx ^ (w_bx << 21);
        w_nb   = rotl(w_bx, 28);
    end

    assign w_poly  = r_step[6] ? r_ph : r_pl;
    assign w_trial = {r_rem, r_num[31]} - {1'b0, r_span};
    assign w_space = !r_ovalid || i_ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && w_space;
    assign w_take  = i_cmd_valid && o_cmd_ready;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_take) begin
                if (i_cmd.kind == CMD_JUMP || i_cmd.kind == CMD_LJUMP) n_state = ST_JUMP;
                else if (i_cmd.kind == CMD_RANGED) n_state = ST_DIV;
            end
            ST_JUMP:     if (r_step == 7'd127) n_state = ST_IDLE;
            ST_DIV:      if (r_bit == 6'd31) n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: if (w_space) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // drop the result once taken, raise it when a new one is written
    always_comb begin
        n_ovalid = r_ovalid && !i_ready;
        if ((r_state == ST_IDLE) && w_take &&
            (i_cmd.kind == CMD_DRAW || i_cmd.kind == CMD_EQUAL)) n_ovalid = 1'b1;
        if ((r_state == ST_OUT_WAIT) && w_space) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_b <= '0; r_acc_a <= '0; r_acc_b <= '0;
            r_step <= '0; r_bit <= '0; r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            unique case (r_state)
                ST_IDLE: if (w_take) begin
                    case (i_cmd.kind)
                        CMD_DRAW: begin
                            r_out.raw_value <= w_draw; r_out.ranged_value <= '0;
                            r_a <= w_na; r_b <= w_nb;
                        end
                        CMD_EQUAL: begin
                            r_out.raw_value <= '0; r_out.ranged_value <= i_cmd.low;
                        end
                        CMD_RANGED: begin
                            r_num <= w_draw[31:0]; r_rem <= '0; r_bit <= '0;
                            r_span <= i_cmd.span; r_low <= i_cmd.low;
                            r_a <= w_na; r_b <= w_nb;
                        end
                        CMD_JUMP, CMD_LJUMP: begin
                            r_pl <= (i_cmd.kind == CMD_JUMP) ? JUMP_POLY_LO : LJUMP_POLY_LO;
                            r_ph <= (i_cmd.kind == CMD_JUMP) ? JUMP_POLY_HI : LJUMP_POLY_HI;
                            r_acc_a <= '0; r_acc_b <= '0; r_step <= '0;
                        end
                        CMD_SEED: begin
                            r_a <= {32'd0, i_cmd.seed_value[63:32]};
                            r_b <= {32'd0, i_cmd.seed_value[31:0]};
                        end
                        default: ;
                    endcase
                end
                ST_JUMP: begin
                    // fold state into accumulator, then advance
                    if (w_poly[r_step[5:0]]) begin
                        if (r_step == 7'd127) begin
                            r_a <= r_acc_a ^ r_a; r_b <= r_acc_b ^ r_b;
                        end
                        r_acc_a <= r_acc_a ^ r_a; r_acc_b <= r_acc_b ^ r_b;
                    end else if (r_step == 7'd127) begin
                        r_a <= r_acc_a; r_b <= r_acc_b;
                    end
                    if (r_step != 7'd127) begin
                        r_a <= w_na; r_b <= w_nb;
                    end
                    r_step <= r_step + 7'd1;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (!w_trial[32]) r_rem <= w_trial[31:0];
                    else              r_rem <= {r_rem[30:0], r_num[31]};
                    r_num <= {r_num[30:0], 1'b0};
                    r_bit <= r_bit + 6'd1;
                end
                ST_OUT_WAIT: if (w_space) begin
                    r_out.raw_value <= '0;
                    r_out.ranged_value <= r_low + r_rem;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== src/xoroshiro_random_generator_core.sv =====
// Top level of the xoroshiro128++ generator.
// Channel | Direction | Handshake           | Payload
// input   | in        | i_valid / o_ready   | i_item (t_in_item)
// output  | out       | o_valid / i_ready   | o_item (t_out_item)
// Draw, seed, equal-bound ranged: done in the back end's idle state.
// Ranged draw: remainder from the one-bit-a-cycle unit, then a wait for output space.
// Jump and long jump: one generator step a cycle in the jump sequencer.
// A two-entry command queue lets input be taken while the back end is busy.
// Reset is synchronous, active low; it zeroes generator and control state only.
module xoroshiro_random_generator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  xrg_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output xrg_pkg::t_out_item o_item
);
    import xrg_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_ready;

    xrg_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    xrg_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_item
    );
endmodule

// ===== dv/xoroshiro_random_generator_core_test.sv =====
// Testbench for the xoroshiro128++ generator core: directed table, then random actions.
module xoroshiro_random_generator_core_test;
    import xrg_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    xoroshiro_random_generator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    always #5 i_clk = ~i_clk;

    // generator state held by the predictor
    logic [63:0] gen_a, gen_b;
    t_out_item   pending_q[$];
    int          mismatches = 0;
    bit          stim_done = 1'b0;
    bit          hold_off = 1'b0;

    typedef struct {
        t_in_item  item;
        bit        known;
        t_out_item result;
    } t_row;

    function automatic logic [63:0] rotl(logic [63:0] v, int k);
        return (v << k) | (v >> (64 - k));
    endfunction

    function automatic logic [63:0] step_gen();
        logic [63:0] a, b, r;
        a = gen_a;
        b = gen_b;
        r = rotl(a + b, 17) + a;
        b = b ^ a;
        gen_a = rotl(a, 49) ^ b ^ (b << 21);
        gen_b = rotl(b, 28);
        return r;
    endfunction

    function automatic void jump_gen(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] acc_a, acc_b, w;
        logic [63:0] junk;
        acc_a = '0;
        acc_b = '0;
        for (int s = 0; s < 128; s++) begin
            w = (s < 64) ? lo : hi;
            if (w[s % 64]) begin
                acc_a ^= gen_a;
                acc_b ^= gen_b;
            end
            junk = step_gen();
        end
        gen_a = acc_a;
        gen_b = acc_b;
    endfunction

    // returns 1 and the expected result when the action yields one
    function automatic bit predict_action(t_in_item it, output t_out_item res);
        logic [31:0] lo, hi, span, val;
        res = '0;
        lo = it.range_low;
        hi = it.range_high;
        case (it.action)
            ACT_DRAW: begin
                res.raw_value = step_gen();
                return 1'b1;
            end
            ACT_RANGED: begin
                if (lo == hi) begin
                    res.ranged_value = lo;
                end else begin
                    span = hi - lo;
                    val = 32'(step_gen());
                    res.ranged_value = lo + (val % span);
                end
                return 1'b1;
            end
            ACT_JUMP:  jump_gen(JUMP_POLY_LO, JUMP_POLY_HI);
            ACT_LJUMP: jump_gen(LJUMP_POLY_LO, LJUMP_POLY_HI);
            ACT_SEED: begin
                gen_a = {32'd0, it.seed_value[63:32]};
                gen_b = {32'd0, it.seed_value[31:0]};
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic report(string what, t_out_item got, t_out_item want);
        $display("%s: raw %h/%h ranged %h/%h", what, got.raw_value, want.raw_value,
                 got.ranged_value, want.ranged_value);
        mismatches++;
    endtask

    function automatic t_in_item mk(t_action act, logic [63:0] sv, logic [31:0] lo,
                                     logic [31:0] hi);
        t_in_item it;
        it.action = act;
        it.seed_value = sv;
        it.range_low = lo;
        it.range_high = hi;
        return it;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // hold valid across back-to-back transfers, drop it only for a gap
    task automatic send(t_in_item it, bit known, t_out_item want);
        t_out_item res;
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!o_ready);
        if (predict_action(it, res)) begin
            if (known && res !== want) report("table row disagrees", res, want);
            pending_q.push_back(res);
        end
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        int pick;
        logic [31:0] lo;
        pick = $urandom_range(0, 99);
        lo = $urandom;
        it.seed_value = {$urandom, $urandom};
        it.range_low = lo;
        if ($urandom_range(0, 1)) it.range_high = lo + $urandom_range(1, 1000);
        else it.range_high = $urandom;
        if (pick < 45) it.action = ACT_DRAW;
        else if (pick < 85) it.action = ACT_RANGED;
        else if (pick < 88) it.action = ACT_JUMP;
        else if (pick < 90) it.action = ACT_LJUMP;
        else if (pick < 97) it.action = ACT_SEED;
        else it.action = 3'($urandom_range(5, 7));
        if (it.action == ACT_RANGED && $urandom_range(0, 19) == 0) it.range_high = lo;
        return it;
    endfunction

    initial begin
        t_row rows[$];
        t_row r;
        t_out_item z;
        z = '0;
        // zero state stays at zero
        r.known = 1'b1; r.result = z;
        r.item = mk(ACT_DRAW, '0, '0, '0); rows.push_back(r);
        r.item = mk(ACT_JUMP, '0, '0, '0); r.known = 1'b0; rows.push_back(r);
        r.item = mk(ACT_DRAW, '0, '0, '0); r.known = 1'b1; rows.push_back(r);
        // equal bounds give range_low
        r.item = mk(ACT_RANGED, '0, 32'h80000000, 32'h80000000);
        r.result = '{raw_value: '0, ranged_value: 32'h80000000}; rows.push_back(r);
        r.item = mk(ACT_RANGED, '0, 32'h7fffffff, 32'h7fffffff);
        r.result = '{raw_value: '0, ranged_value: 32'h7fffffff}; rows.push_back(r);
        r.known = 1'b0;
        r.item = mk(ACT_SEED, 64'hffffffffffffffff, '0, '0); rows.push_back(r);
        r.item = mk(ACT_DRAW, '0, '0, '0); rows.push_back(r);
        r.item = mk(ACT_RANGED, '0, 32'h80000000, 32'h7fffffff); rows.push_back(r);
        r.item = mk(ACT_RANGED, '0, 32'h7fffffff, 32'h80000000); rows.push_back(r);
        r.item = mk(ACT_RANGED, '0, 32'd0, 32'd1); rows.push_back(r);
        r.item = mk(ACT_RANGED, '0, 32'hffffffff, 32'hfffffffe); rows.push_back(r);
        r.item = mk(ACT_SEED, 64'h0000000100000000, '0, '0); rows.push_back(r);
        r.item = mk(ACT_DRAW, '0, '0, '0); rows.push_back(r);
        r.item = mk(ACT_JUMP, '0, '0, '0); rows.push_back(r);
        r.item = mk(ACT_DRAW, '0, '0, '0); rows.push_back(r);
        r.item = mk(ACT_LJUMP, '0, '0, '0); rows.push_back(r);
        r.item = mk(ACT_RANGED, '0, 32'hfffffc00, 32'h00000400); rows.push_back(r);
        r.item = mk(t_action'(3'd5), '1, '1, '1); rows.push_back(r);
        r.item = mk(t_action'(3'd7), '1, '0, '1); rows.push_back(r);
        r.item = mk(ACT_SEED, 64'h123456789abcdef0, '0, '0); rows.push_back(r);
        r.item = mk(ACT_DRAW, '0, '0, '0); rows.push_back(r);

        gen_a = '0;
        gen_b = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[k]) send(rows[k].item, rows[k].known, rows[k].result);
        for (int n = 0; n < 450; n++) begin
            if (n == 150) hold_off = 1'b1;
            send(rand_item(), 1'b0, z);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, with one long hold-off
    initial begin
        int g;
        int held;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                i_ready <= 1'b0;
                for (held = 0; held < 400; held++) @(posedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                report("result with nothing expected", o_item, '0);
            end else begin
                if (o_item.raw_value !== pending_q[0].raw_value)
                    report("raw_value", o_item, pending_q[0]);
                else if (o_item.ranged_value !== pending_q[0].ranged_value)
                    report("ranged_value", o_item, pending_q[0]);
                void'(pending_q.pop_front());
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) $display("xoroshiro_random_generator_core: match");
        else $display("xoroshiro_random_generator_core: mismatch");
        $finish;
    end

    initial begin
        #10000000;
        $display("xoroshiro_random_generator_core: mismatch");
        $finish;
    end
endmodule
